FILE: hw/rtl/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while the active-low reset is asserted.
`define SSR_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define SSR_NEVER(lbl, ck, rn, expr, msg) \
	`SSR_ASSERT(lbl, ck, rn, (!(expr)), msg)

`endif

FILE: hw/rtl/ssr_pkg.sv
// Types, constants and the stand pose lookup for the smoothstep setpoint ramp.
`timescale 1ns / 1ps
`default_nettype none

package ssr_pkg;

	// configuration port
	localparam int CFG_IW = 1;
	localparam logic [CFG_IW-1:0] CFG_RAMP = 1'd0;
	localparam logic [CFG_IW-1:0] CFG_RUN  = 1'd1;
	localparam logic [15:0] RAMP_RST = 16'd1500;
	localparam logic [23:0] RUN_RST  = 24'd5000;

	// command opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

	// stand pose, Q3.16
	localparam logic signed [19:0] HIP_Q16   = 20'sd375;
	localparam logic signed [19:0] THIGH_Q16 = 20'sd39899;
	localparam logic signed [19:0] CALF_Q16  = -20'sd79799;

	// gains, Q7.8 stiffness and Q2.8 damping
	localparam logic [9:0]  KD_Q8     = 10'd896;
	localparam logic [14:0] KP_MIN_Q8 = 15'd5120;
	localparam logic [14:0] KP_MAX_Q8 = 15'd25600;
	localparam logic signed [21:0] KP_SPAN = 22'sd20480;

	// smoothstep
	localparam logic [16:0] PHASE_ONE = 17'd65536;
	localparam logic [17:0] CUBE_K    = 18'd196608;

	// microcode
	localparam int SW = 4;
	localparam int CW = 3;
	localparam logic [1:0] MS_SQ   = 2'd0;
	localparam logic [1:0] MS_CUBE = 2'd1;
	localparam logic [1:0] MS_KP   = 2'd2;
	localparam logic [1:0] MS_TGT  = 2'd3;

	typedef struct packed {
		logic          mul_en;
		logic [1:0]    mul_sel;
		logic          div_init;
		logic          div_step;
		logic          wr_phase;
		logic          wr_kp;
		logic          wr_diff;
		logic          rd_pose;
		logic          rd_next;
		logic          emit;
		logic          inc_j;
		logic          wait_out;
		logic          fin;
		logic [CW-1:0] cond;
		logic [SW-1:0] target;
	} uword_t;

	typedef struct packed {
		logic no_ramp;
		logic div_busy;
		logic last;
		logic out_busy;
	} seq_flags_t;

	// part: 0 hip, 1 thigh, 2 calf; hip sign flips on odd legs
	function automatic logic signed [19:0] stand_of(input logic [1:0] part,
			input logic leg_odd);
		logic signed [19:0] s;
		case (part)
			2'd1: s = THIGH_Q16;
			2'd2: s = CALF_Q16;
			default: s = leg_odd ? -HIP_Q16 : HIP_Q16;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/smoothstep_joint_setpoint_ramp_top.sv
// Smoothstep joint setpoint ramp: command intake, datapath and result register.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+--------------------------------------------
//  cmd      | in  | cmd_valid / cmd_stall  | operation, joint_index, start_position
//  sp       | out | sp_valid / sp_stall    | out_joint, target_position, stiffness_gain,
//           |     |                        | damping_gain, last_joint, done_res
//  cfg      | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  A load or an idle tick is a one-cycle transfer. An active tick holds cmd_stall while the
//  sequencer runs: inside the ramp the bit-serial divider, smoothstep and gain steps, then
//  target, emit and difference steps per joint on the shared multiplier; past the ramp the
//  divider and smoothstep are skipped. A stalled setpoint costs the sequencer nothing during
//  the difference and target steps; one still on at the next emit step holds it there.
//  The result register lets the next command transfer while the last setpoint waits.
//  Reset clears arming, the tick counter and the finished flag; start poses are undefined.
`timescale 1ns / 1ps
`default_nettype none

module smoothstep_joint_setpoint_ramp_top import ssr_pkg::*; #(
	parameter int JOINTS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	// command channel
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  logic              operation,
	input  logic [3:0]        joint_index,
	input  logic signed [19:0] start_position,
	// setpoint channel
	output logic              sp_valid,
	input  logic              sp_stall,
	output logic [3:0]        out_joint,
	output logic signed [19:0] target_position,
	output logic [14:0]       stiffness_gain,
	output logic [9:0]        damping_gain,
	output logic              last_joint,
	output logic              done_res,
	// configuration channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [23:0]       cfg_data
);

	localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	// configuration and run state
	logic [15:0] ramp_q;
	logic [23:0] run_q;
	logic        armed_q;
	logic        fin_q;
	logic [23:0] tick_q;
	logic        ramping_q;
	logic        done_q;

	// start pose store
	logic signed [19:0] pose_mem [JOINTS];
	logic signed [19:0] pose_rd_q;
	logic [JW-1:0]      rd_addr;
	logic               rd_fire;

	// joint walk
	logic [JW-1:0] jidx_q;
	logic [1:0]    part_q;
	logic          leg_odd_q;
	logic          last;

	// divider: x = floor(tick * 2^16 / ramp), one quotient bit a step
	logic [16:0] rem_q;
	logic [15:0] x_q;
	logic [3:0]  dcnt_q;
	logic [16:0] rem_dbl;

	// shared multiplier and its operand registers
	logic signed [32:0] mul_a;
	logic signed [21:0] mul_b;
	logic signed [54:0] prod_q;
	logic [16:0]        phase_q;
	logic [14:0]        kp_q;
	logic signed [20:0] diff_q;
	logic signed [19:0] stand;
	logic [50:0]        ph_sum;
	logic [31:0]        kp_sum;
	logic signed [38:0] rnd;
	logic signed [19:0] tgt_nx;

	// result register
	logic              sp_valid_q;
	logic [3:0]        joint_q;
	logic signed [19:0] tgt_q;
	logic [14:0]       kp_out_q;
	logic              last_q;
	logic              done_out_q;

	// command decode
	logic        cmd_take;
	logic        load_take;
	logic        tick_go;
	logic [23:0] tick_nx;

	seq_flags_t flags;
	uword_t     ctrl;
	logic       busy;

	assign cmd_take  = cmd_valid && !cmd_stall;
	assign load_take = cmd_take && (operation == OP_LOAD) && (32'(joint_index) < JOINTS);
	assign tick_go   = cmd_take && (operation == OP_TICK) && armed_q && !fin_q;
	assign tick_nx   = (tick_q == COUNT_MAX) ? tick_q : tick_q + 24'd1;

	assign last = (jidx_q == JW'(JOINTS - 1));

	assign flags.no_ramp  = !ramping_q;
	assign flags.div_busy = (dcnt_q != 4'd15);
	assign flags.last     = last;
	assign flags.out_busy = sp_valid_q && sp_stall;

	ssr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (tick_go),
		.flags  (flags),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// command side stalls only while a tick is being worked
	assign cmd_stall = busy;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_q  <= RAMP_RST;
			run_q   <= RUN_RST;
			armed_q <= 1'b0;
			fin_q   <= 1'b0;
			tick_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_RAMP: ramp_q <= cfg_data[15:0];
					CFG_RUN:  run_q  <= cfg_data;
					default: ;
				endcase
			end
			// loading the last joint arms; re-arming keeps count and finished flag
			if (load_take && (32'(joint_index) == JOINTS - 1)) begin
				armed_q <= 1'b1;
			end
			if (tick_go) begin
				tick_q <= tick_nx;
				if (tick_nx >= run_q) begin
					fin_q <= 1'b1;
				end
			end
		end
	end

	// per-tick flags, joint walk and divider counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramping_q <= 1'b0;
			done_q    <= 1'b0;
			jidx_q    <= '0;
			part_q    <= 2'd0;
			leg_odd_q <= 1'b0;
			dcnt_q    <= '0;
		end else begin
			if (tick_go) begin
				ramping_q <= (tick_nx < {8'd0, ramp_q});
				done_q    <= (tick_nx >= run_q);
				jidx_q    <= '0;
				part_q    <= 2'd0;
				leg_odd_q <= 1'b0;
			end else if (ctrl.inc_j) begin
				jidx_q <= JW'(jidx_q + 1'b1);
				if (part_q == 2'd2) begin
					part_q    <= 2'd0;
					leg_odd_q <= !leg_odd_q;
				end else begin
					part_q <= part_q + 2'd1;
				end
			end
			if (ctrl.div_init) begin
				dcnt_q <= '0;
			end else if (ctrl.div_step) begin
				dcnt_q <= dcnt_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_take) begin
			pose_mem[JW'(joint_index)] <= start_position;
		end
		if (rd_fire) begin
			pose_rd_q <= pose_mem[rd_addr];
		end
	end

	// next-joint read is skipped on the last joint
	assign rd_addr = ctrl.rd_next ? JW'(jidx_q + 1'b1) : jidx_q;
	assign rd_fire = ctrl.rd_pose && !(ctrl.rd_next && last);

	assign rem_dbl = {rem_q[15:0], 1'b0};
	assign stand   = stand_of(part_q, leg_odd_q);

	always_comb begin
		case (ctrl.mul_sel)
			MS_SQ: begin
				mul_a = {17'd0, x_q};
				mul_b = {6'd0, x_q};
			end
			MS_CUBE: begin
				mul_a = {1'b0, prod_q[31:0]};
				mul_b = {4'd0, CUBE_K - {1'b0, x_q, 1'b0}};
			end
			MS_KP: begin
				mul_a = {16'd0, phase_q};
				mul_b = KP_SPAN;
			end
			MS_TGT: begin
				mul_a = {16'd0, phase_q};
				mul_b = {diff_q[20], diff_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// phase = (x^2 * (3 - 2x) + half) >> 32
	assign ph_sum = {1'b0, prod_q[49:0]} + 51'h0_8000_0000;
	assign kp_sum = prod_q[31:0] + 32'd32768;
	// halves round away from zero
	assign rnd    = prod_q[38:0] + (prod_q[38] ? 39'sd32767 : 39'sd32768);
	assign tgt_nx = pose_rd_q + 20'(rnd >>> 16);

	always_ff @(posedge clk) begin
		if (ctrl.div_init) begin
			rem_q <= {1'b0, tick_q[15:0]};
			x_q   <= '0;
		end else if (ctrl.div_step) begin
			if (rem_dbl >= {1'b0, ramp_q}) begin
				rem_q <= rem_dbl - {1'b0, ramp_q};
				x_q   <= {x_q[14:0], 1'b1};
			end else begin
				rem_q <= rem_dbl;
				x_q   <= {x_q[14:0], 1'b0};
			end
		end
		if (ctrl.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		// past the ramp the phase is one: the gain lands on its maximum, targets on the stand pose
		if (tick_go) begin
			phase_q <= PHASE_ONE;
		end else if (ctrl.wr_phase) begin
			phase_q <= ph_sum[48:32];
		end
		if (ctrl.wr_kp) begin
			kp_q <= KP_MIN_Q8 + kp_sum[30:16];
		end
		if (ctrl.wr_diff) begin
			diff_q <= {stand[19], stand} - {pose_rd_q[19], pose_rd_q};
		end
		if (ctrl.emit) begin
			joint_q    <= 4'(jidx_q);
			tgt_q      <= tgt_nx;
			kp_out_q   <= kp_q;
			last_q     <= last;
			done_out_q <= done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			sp_valid_q <= 1'b1;
		end else if (!sp_stall) begin
			sp_valid_q <= 1'b0;
		end
	end

	assign sp_valid        = sp_valid_q;
	assign out_joint       = joint_q;
	assign target_position = tgt_q;
	assign stiffness_gain  = kp_out_q;
	assign damping_gain    = KD_Q8;
	assign last_joint      = last_q;
	assign done_res        = done_out_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ssr_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
`timescale 1ns / 1ps
`default_nettype none

module ssr_seq import ssr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  seq_flags_t flags,
	output uword_t     ctrl,
	output logic       busy
);

	localparam logic [CW-1:0] C_NEXT     = 3'd0;
	localparam logic [CW-1:0] C_ALWAYS   = 3'd1;
	localparam logic [CW-1:0] C_NO_RAMP  = 3'd2;
	localparam logic [CW-1:0] C_DIV_BUSY = 3'd3;
	localparam logic [CW-1:0] C_LAST     = 3'd4;

	localparam logic [SW-1:0] ST_CHK  = 4'd0;
	localparam logic [SW-1:0] ST_DIV  = 4'd1;
	localparam logic [SW-1:0] ST_SQ   = 4'd2;
	localparam logic [SW-1:0] ST_CUBE = 4'd3;
	localparam logic [SW-1:0] ST_PH   = 4'd4;
	localparam logic [SW-1:0] ST_KP   = 4'd5;
	localparam logic [SW-1:0] ST_KPW  = 4'd6;
	localparam logic [SW-1:0] ST_TG   = 4'd7;
	localparam logic [SW-1:0] ST_EM   = 4'd8;
	localparam logic [SW-1:0] ST_DF   = 4'd9;
	localparam logic [SW-1:0] ST_FIN  = 4'd10;

	function automatic uword_t ucode(input logic [SW-1:0] step);
		uword_t w;
		w = '0;
		case (step)
			ST_CHK: begin
				w.div_init = 1'b1;
				w.cond     = C_NO_RAMP;
				w.target   = ST_KP;
			end
			ST_DIV: begin
				w.div_step = 1'b1;
				w.cond     = C_DIV_BUSY;
				w.target   = ST_DIV;
			end
			ST_SQ: begin
				w.mul_en  = 1'b1;
				w.mul_sel = MS_SQ;
			end
			ST_CUBE: begin
				w.mul_en  = 1'b1;
				w.mul_sel = MS_CUBE;
			end
			ST_PH: begin
				w.wr_phase = 1'b1;
			end
			ST_KP: begin
				w.mul_en  = 1'b1;
				w.mul_sel = MS_KP;
				w.rd_pose = 1'b1;
			end
			ST_KPW: begin
				w.wr_kp   = 1'b1;
				w.wr_diff = 1'b1;
			end
			ST_TG: begin
				w.mul_en  = 1'b1;
				w.mul_sel = MS_TGT;
			end
			ST_EM: begin
				w.wait_out = 1'b1;
				w.emit     = 1'b1;
				w.inc_j    = 1'b1;
				w.rd_pose  = 1'b1;
				w.rd_next  = 1'b1;
				w.cond     = C_LAST;
				w.target   = ST_FIN;
			end
			ST_DF: begin
				w.wr_diff = 1'b1;
				w.cond    = C_ALWAYS;
				w.target  = ST_TG;
			end
			ST_FIN: begin
				w.fin = 1'b1;
			end
			default: begin
				w.fin = 1'b1;
			end
		endcase
		return w;
	endfunction

	logic [SW-1:0] step_q;
	logic          busy_q;
	uword_t        word;
	logic          hold;
	logic          take;

	always_comb begin
		word = ucode(step_q);
		hold = word.wait_out && flags.out_busy;
		case (word.cond)
			C_NEXT:     take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_RAMP:  take = flags.no_ramp;
			C_DIV_BUSY: take = flags.div_busy;
			C_LAST:     take = flags.last;
			default:    take = 1'b0;
		endcase
		ctrl = (busy_q && !hold) ? word : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= ST_CHK;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= ST_CHK;
		end else if (busy_q && !hold) begin
			if (word.fin) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= take ? word.target : step_q + 4'd1;
			end
		end
	end

	assign busy = busy_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ssr_chk.sv
// Port-level checker for the setpoint ramp, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ssr_chk import ssr_pkg::*; #(
	parameter int JOINTS = 12
) (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_stall,
	input logic              operation,
	input logic              sp_valid,
	input logic              sp_stall,
	input logic [3:0]        out_joint,
	input logic signed [19:0] target_position,
	input logic [14:0]       stiffness_gain,
	input logic              last_joint
);

	`SSR_ASSERT(a_sp_hold, clk, arst_n, (sp_valid && sp_stall |=> sp_valid && $stable(target_position) && $stable(out_joint)), "setpoint dropped or changed under stall")

	`SSR_NEVER(a_kp_range, clk, arst_n, sp_valid && (stiffness_gain < KP_MIN_Q8 || stiffness_gain > KP_MAX_Q8), "kp outside 20..100")

	`SSR_ASSERT(a_last_joint, clk, arst_n, (sp_valid && last_joint |-> out_joint == 4'(JOINTS - 1)), "last flag on wrong joint")

	`SSR_ASSERT(a_stall_cause, clk, arst_n, ($rose(cmd_stall) |-> $past(cmd_valid && operation == OP_TICK)), "command stall without a tick transfer")

endmodule

bind smoothstep_joint_setpoint_ramp_top ssr_chk #(.JOINTS(JOINTS)) u_ssr_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd_valid),
	.cmd_stall       (cmd_stall),
	.operation       (operation),
	.sp_valid        (sp_valid),
	.sp_stall        (sp_stall),
	.out_joint       (out_joint),
	.target_position (target_position),
	.stiffness_gain  (stiffness_gain),
	.last_joint      (last_joint)
);

`default_nettype wire

FILE: sim/smoothstep_joint_setpoint_ramp_top_tb.sv
// Self-checking testbench for the smoothstep joint setpoint ramp: predicted setpoints vs. DUT.
`timescale 1ns / 1ps

module smoothstep_joint_setpoint_ramp_top_tb;
	import ssr_pkg::*;

	localparam int JOINTS = 12;
	localparam int RANDOM_ITEMS = 400;
	// time for an active tick plus result-register drain; generous margin
	localparam int SETTLE_CYCLES = 100;
	// worst case ~500 ticks with long stalls and gaps is ~9 ms; allow far more
	localparam longint TIMEOUT_NS = 64'd50_000_000;

	// one command transfer
	typedef struct {
		logic              op;
		logic [3:0]        jnt;
		logic signed [19:0] pos;
	} cmd_t;

	// one setpoint transfer
	typedef struct {
		logic [3:0]        joint;
		logic signed [19:0] target;
		logic [14:0]       kp;
		logic [9:0]        kd;
		logic              last;
		logic              done;
	} setpoint_t;

	// ---------------------------------------------------------------------------
	// DUT inputs, all known from time zero
	// ---------------------------------------------------------------------------
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cmd_valid = 1'b0;
	logic              operation = OP_LOAD;
	logic [3:0]        joint_index = 4'd0;
	logic signed [19:0] start_position = 20'sd0;
	logic              sp_stall = 1'b0;
	logic              cfg_valid = 1'b0;
	logic [CFG_IW-1:0] cfg_index = CFG_RAMP;
	logic [23:0]       cfg_data = 24'd0;

	// DUT outputs
	wire               cmd_stall;
	wire               sp_valid;
	wire [3:0]         out_joint;
	wire signed [19:0] target_position;
	wire [14:0]        stiffness_gain;
	wire [9:0]         damping_gain;
	wire               last_joint;
	wire               done_res;
	wire               cfg_ready;

	smoothstep_joint_setpoint_ramp_top #(.JOINTS(JOINTS)) DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd_stall       (cmd_stall),
		.operation       (operation),
		.joint_index     (joint_index),
		.start_position  (start_position),
		.sp_valid        (sp_valid),
		.sp_stall        (sp_stall),
		.out_joint       (out_joint),
		.target_position (target_position),
		.stiffness_gain  (stiffness_gain),
		.damping_gain    (damping_gain),
		.last_joint      (last_joint),
		.done_res        (done_res),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------------------
	// Shadow state of the ramp generator, updated on each accepted command
	// ---------------------------------------------------------------------------
	logic signed [19:0] start_pose [JOINTS];
	logic               armed = 1'b0;
	logic [23:0]        tick_cnt = 24'd0;
	logic               finished = 1'b0;
	logic [15:0]        ramp_len = RAMP_RST;
	logic [23:0]        run_len = RUN_RST;

	cmd_t      cmd_q[$];        // commands waiting for the driver
	setpoint_t setpoint_q[$];   // setpoints predicted, not yet seen

	cmd_t        cur_cmd;
	int unsigned cmds_sent = 0;
	int unsigned cmds_taken = 0;
	int unsigned loads_sent = 0;
	int unsigned ticks_sent = 0;
	int unsigned active_ticks = 0;
	int unsigned cfg_writes = 0;
	int unsigned setpoints_seen = 0;
	int unsigned done_seen = 0;
	int unsigned errors = 0;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	bit          quiet = 1'b0;   // no idling on either side while set

	// Gap length: mostly none or short, now and then long.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [19:0] rand_pos();
		case ($urandom_range(0, 9))
			0: return 20'sh80000;
			1: return 20'sh7FFFF;
			2: return 20'sh00000;
			default: return 20'($urandom);
		endcase
	endfunction

	// Apply one command to the shadow state; an active tick yields one setpoint per joint.
	function automatic void predict_setpoints(cmd_t c);
		longint    x, p, phase, kp, stand, diff, prod, delta, tgt;
		logic      ramping, done;
		setpoint_t s;
		if (c.op == OP_LOAD) begin
			if (c.jnt < JOINTS) begin
				start_pose[c.jnt] = c.pos;
				if (c.jnt == JOINTS - 1)
					armed = 1'b1;
			end
			return;
		end
		if (finished || !armed)
			return;
		active_ticks++;
		if (tick_cnt != COUNT_MAX)
			tick_cnt++;
		ramping = (tick_cnt < ramp_len);
		if (ramping) begin
			// x = count/len in Q0.16, phase = 3x^2 - 2x^3 rounded to Q0.16
			x = (longint'(tick_cnt) << 16) / longint'(ramp_len);
			p = x * x * (64'sd196608 - 2 * x);
			phase = (p + 64'sh8000_0000) >>> 32;
			kp = longint'(KP_MIN_Q8) + ((64'sd20480 * phase + 64'sd32768) >>> 16);
		end else begin
			phase = 65536;
			kp = longint'(KP_MAX_Q8);
		end
		done = (tick_cnt >= run_len);
		if (done)
			finished = 1'b1;
		for (int j = 0; j < JOINTS; j++) begin
			case (j % 3)
				1: stand = THIGH_Q16;
				2: stand = CALF_Q16;
				default: stand = ((j / 3) % 2 == 0) ? HIP_Q16 : -HIP_Q16;
			endcase
			if (ramping) begin
				diff = stand - longint'(start_pose[j]);
				prod = phase * diff;
				// halves away from zero
				if (prod >= 0)
					delta = (prod + 32768) >>> 16;
				else
					delta = -((-prod + 32768) >>> 16);
				tgt = longint'(start_pose[j]) + delta;
			end else begin
				tgt = stand;
			end
			s.joint  = 4'(j);
			s.target = tgt[19:0];
			s.kp     = kp[14:0];
			s.kd     = KD_Q8;
			s.last   = (j == JOINTS - 1);
			s.done   = done;
			setpoint_q.push_back(s);
		end
	endfunction

	function automatic void check_field(string name, logic signed [31:0] want,
			logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// ---------------------------------------------------------------------------
	// Command driver: payload held while stalled, gap drawn after each transfer
	// ---------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				predict_setpoints(cur_cmd);
				cmds_taken++;
			end
			if (!cmd_valid || !cmd_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					cmd_valid <= 1'b0;
				end else if (cmd_q.size() != 0) begin
					cur_cmd = cmd_q.pop_front();
					cmd_valid      <= 1'b1;
					operation      <= cur_cmd.op;
					joint_index    <= cur_cmd.jnt;
					start_position <= cur_cmd.pos;
					send_gap = quiet ? 0 : idle_len();
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------------
	// Setpoint monitor: checks each transfer against the oldest prediction,
	// and throttles the sink with random stall bursts
	// ---------------------------------------------------------------------------
	always @(posedge clk) begin
		setpoint_t want;
		if (!arst_n) begin
			sp_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (sp_valid && !sp_stall) begin
				setpoints_seen++;
				if (setpoint_q.size() == 0) begin
					$error("unexpected setpoint transfer for joint %0d", out_joint);
					errors++;
				end else begin
					want = setpoint_q.pop_front();
					if (want.done)
						done_seen++;
					check_field("out_joint", want.joint, out_joint);
					check_field("target_position", want.target, target_position);
					check_field("stiffness_gain", want.kp, stiffness_gain);
					check_field("damping_gain", want.kd, damping_gain);
					check_field("last_joint", want.last, last_joint);
					check_field("done_res", want.done, done_res);
				end
			end
			if (stall_left > 0)
				stall_left--;
			else if (!quiet && $urandom_range(0, 2) == 0)
				stall_left = idle_len();
			sp_stall <= (stall_left != 0);
		end
	end

	// ---------------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------------
	task automatic push_cmd(input logic op, input logic [3:0] jnt,
			input logic signed [19:0] pos);
		cmd_t c;
		c.op  = op;
		c.jnt = jnt;
		c.pos = pos;
		cmd_q.push_back(c);
		cmds_sent++;
		if (op == OP_TICK)
			ticks_sent++;
		else
			loads_sent++;
	endtask

	// Hold off until every command has transferred and every setpoint has arrived,
	// then give the sequencer time to go idle. Returns on a rising edge.
	task automatic settle();
		while (cmds_taken != cmds_sent || setpoint_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write; call on a rising edge with the block idle.
	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_RAMP)
			ramp_len = val[15:0];
		else if (idx == CFG_RUN)
			run_len = val;
		cfg_writes++;
		@(posedge clk);
	endtask

	initial begin
		int unsigned counted, n, r, ramp_new, extra;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed: arming, bad indexes, extreme positions, reload while armed
		push_cmd(OP_TICK, 4'd0, 20'sd0);            // tick before arming: ignored
		push_cmd(OP_LOAD, 4'd15, 20'sh80000);       // out-of-range joints: ignored
		push_cmd(OP_LOAD, 4'd12, 20'sh7FFFF);
		push_cmd(OP_LOAD, 4'd0, 20'sh80000);
		push_cmd(OP_LOAD, 4'd1, 20'sh7FFFF);
		push_cmd(OP_LOAD, 4'd2, 20'sh00000);
		push_cmd(OP_LOAD, 4'd3, 20'shFFFFF);
		push_cmd(OP_LOAD, 4'd4, 20'sh00001);
		for (int j = 5; j < JOINTS - 1; j++)
			push_cmd(OP_LOAD, 4'(j), rand_pos());
		push_cmd(OP_TICK, 4'd11, 20'sh55555);       // still unarmed
		push_cmd(OP_LOAD, 4'(JOINTS - 1), 20'shAAAAA); // last joint arms
		push_cmd(OP_TICK, 4'd0, 20'sd0);
		push_cmd(OP_TICK, 4'd0, 20'sd0);
		push_cmd(OP_LOAD, 4'd4, 20'sh7FFFF);        // new start takes effect next tick
		push_cmd(OP_LOAD, 4'(JOINTS - 1), 20'sh80000); // arming again: no restart
		push_cmd(OP_TICK, 4'd0, 20'sd0);
		push_cmd(OP_LOAD, 4'd13, 20'sh12345);
		push_cmd(OP_TICK, 4'd0, 20'sd0);
		settle();

		// ramp of one tick is already over: stand pose, full stiffness
		write_reg(CFG_RAMP, 24'd1);
		push_cmd(OP_TICK, 4'd0, 20'sd0);
		settle();
		// no ramp at all
		write_reg(CFG_RAMP, 24'd0);
		push_cmd(OP_TICK, 4'd0, 20'sd0);
		settle();
		// longest ramp: phase close to zero
		write_reg(CFG_RAMP, 24'd65535);
		write_reg(CFG_RUN, COUNT_MAX);
		push_cmd(OP_TICK, 4'd0, 20'sd0);
		push_cmd(OP_TICK, 4'd0, 20'sd0);

		// --- random phases, each with its own ramp length and idling mode
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			settle();
			quiet = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 5))
				0: ramp_new = tick_cnt + $urandom_range(1, 30);       // ends soon
				1, 2: ramp_new = $urandom_range(tick_cnt + 1, tick_cnt * 3 + 200);
				3: ramp_new = 65535;
				4: ramp_new = $urandom_range(1, tick_cnt);            // already past
				default: ramp_new = 0;
			endcase
			if (ramp_new > 65535)
				ramp_new = 65535;
			write_reg(CFG_RAMP, 24'(ramp_new));
			// keep the end of the run well clear of this phase
			if ($urandom_range(0, 1) == 0)
				write_reg(CFG_RUN, COUNT_MAX);
			else
				write_reg(CFG_RUN, 24'($urandom_range(tick_cnt + 2000, COUNT_MAX)));
			n = $urandom_range(12, 40);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					push_cmd(OP_TICK, 4'($urandom), 20'($urandom));
					counted++;
				end else if (r < 92) begin
					push_cmd(OP_LOAD, 4'($urandom_range(0, JOINTS - 1)), rand_pos());
					counted++;
				end else begin
					push_cmd(OP_LOAD, 4'($urandom_range(JOINTS, 15)), rand_pos());
				end
			end
		end

		// --- finish the run: done on the tick that reaches the end, then silence
		settle();
		quiet = 1'b0;
		write_reg(CFG_RAMP, 24'(tick_cnt + $urandom_range(1, 10)));
		extra = $urandom_range(2, 8);
		write_reg(CFG_RUN, 24'(tick_cnt + extra));
		repeat (extra + 4) begin
			push_cmd(OP_TICK, 4'd0, 20'sd0);
			if ($urandom_range(0, 3) == 0)
				push_cmd(OP_LOAD, 4'($urandom_range(0, JOINTS - 1)), rand_pos());
		end
		settle();
		write_reg(CFG_RUN, 24'd1);
		write_reg(CFG_RUN, 24'd0);
		push_cmd(OP_TICK, 4'd0, 20'sd0);
		push_cmd(OP_LOAD, 4'(JOINTS - 1), rand_pos());
		push_cmd(OP_TICK, 4'd0, 20'sd0);
		settle();

		$display("Run covered %0d loads and %0d ticks (%0d active), %0d register writes.",
			loads_sent, ticks_sent, active_ticks, cfg_writes);
		$display("%0d setpoints checked, %0d flagged done; run finished: %0d.",
			setpoints_seen, done_seen, finished);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/ssr_pkg.sv
hw/rtl/ssr_seq.sv
hw/rtl/smoothstep_joint_setpoint_ramp_top.sv
hw/rtl/ssr_chk.sv
sim/smoothstep_joint_setpoint_ramp_top_tb.sv
